// ===== design/slipfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slipfr_pkg;

  // frame buffer limit and derived widths
  localparam int RX_BUF_DEPTH = 512;
  localparam int CNT_W        = $clog2(RX_BUF_DEPTH + 1);
  localparam int IDX_W        = 9;

  // decoupling queue between decoder and frame checker
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // slip codes
  localparam logic [7:0] END_CODE     = 8'hC0;
  localparam logic [7:0] ESC_CODE     = 8'hDB;
  localparam logic [7:0] ESC_END_CODE = 8'hDC;
  localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

  // frame header
  localparam logic [7:0] FRAME_MAGIC   = 8'hF1;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam int         HEADER_BYTES  = 6;
  localparam int         MIN_FRAME     = 24;
  localparam int         POS_MAGIC     = 0;
  localparam int         POS_VERSION   = 1;
  localparam int         POS_SEQ       = 3;
  localparam int         POS_CMD       = 4;
  localparam int         POS_LEN       = 5;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_VERDICT  = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_LEN     = 3'd3,
    ST_CRC     = 3'd4
  } status_e;

  // one decoded symbol: frame end or a data byte
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } op_t;

  // crc16-ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] v);
    logic [15:0] c;
    c = crc ^ {v, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/slipfr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface slipfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slipfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [8:0] byte_index;
  logic [2:0] status;
  logic [7:0] frame_payload_len;
  logic [7:0] frame_seq;
  logic [7:0] frame_cmd;
  logic       frame_done;

  modport source (
    output valid, output kind, output data_byte, output byte_index, output status,
    output frame_payload_len, output frame_seq, output frame_cmd, output frame_done,
    input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input byte_index, input status,
    input frame_payload_len, input frame_seq, input frame_cmd, input frame_done,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/slipfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slipfr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  slipfr_in_if.sink         rx_i,
  output slipfr_pkg::op_t   op_o,
  output logic              op_valid_o,
  input  wire logic         op_ready_i
);
  import slipfr_pkg::*;

  logic       esc_q, esc_d;
  logic       accept;
  logic [7:0] b;

  assign rx_i.ready = op_ready_i;
  assign accept     = rx_i.valid && op_ready_i;
  assign b          = rx_i.rx_byte;

  always_comb begin
    op_o.is_end = 1'b0;
    op_o.data   = b;
    op_valid_o  = 1'b0;
    esc_d       = esc_q;
    priority if (b == END_CODE) begin
      op_o.is_end = 1'b1;
      op_valid_o  = rx_i.valid;
      if (accept) begin
        esc_d = 1'b0;
      end
    end else if (b == ESC_CODE) begin
      // escape byte only arms the decoder
      if (accept) begin
        esc_d = 1'b1;
      end
    end else begin
      op_valid_o = rx_i.valid;
      if (esc_q) begin
        priority if (b == ESC_END_CODE) begin
          op_o.data = END_CODE;
        end else if (b == ESC_ESC_CODE) begin
          op_o.data = ESC_CODE;
        end else begin
          op_o.data = b;
        end
      end
      if (accept) begin
        esc_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/slipfr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slipfr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slipfr_pkg::op_t   wr_op_i,
  input  wire logic              wr_valid_i,
  output logic                   wr_ready_o,
  output slipfr_pkg::op_t        rd_op_o,
  output logic                   rd_valid_o,
  input  wire logic              rd_ready_i
);
  import slipfr_pkg::*;

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_op_o    = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/slipfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slipfr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire slipfr_pkg::op_t  op_i,
  input  wire logic             op_valid_i,
  output logic                  op_ready_o,
  slipfr_out_if.source          res_o
);
  import slipfr_pkg::*;

  // frame state
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      rcrc_q, rcrc_d;
  logic [7:0]       magic_q, magic_d;
  logic [7:0]       ver_q, ver_d;
  logic [7:0]       seq_q, seq_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       data_q, data_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]       status_q, status_d;
  logic [7:0]       rlen_q, rlen_d;
  logic [7:0]       rseq_q, rseq_d;
  logic [7:0]       rcmd_q, rcmd_d;
  logic             done_q, done_d;

  logic             take;
  logic [15:0]      count_w;
  logic [15:0]      crc_pos;
  status_e          verdict;

  assign op_ready_o = !out_valid_q || res_o.ready;
  assign take       = op_valid_i && op_ready_o;
  assign count_w    = 16'(count_q);
  assign crc_pos    = 16'(HEADER_BYTES) + 16'(len_q);

  always_comb begin
    priority if (count_q < CNT_W'(MIN_FRAME)) begin
      verdict = ST_SHORT;
    end else if (magic_q != FRAME_MAGIC || ver_q != FRAME_VERSION) begin
      verdict = ST_BAD_HDR;
    end else if (count_w != 16'(MIN_FRAME) + 16'(len_q)) begin
      verdict = ST_LEN;
    end else if (crc_q != rcrc_q) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    count_d     = count_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    magic_d     = magic_q;
    ver_d       = ver_q;
    seq_d       = seq_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !res_o.ready;
    load        = 1'b0;
    kind_d      = KIND_DATA;
    data_d      = '0;
    idx_d       = '0;
    status_d    = ST_OK;
    rlen_d      = '0;
    rseq_d      = '0;
    rcmd_d      = '0;
    done_d      = 1'b0;

    if (take) begin
      priority if (op_i.is_end || count_q == CNT_W'(RX_BUF_DEPTH)) begin
        // frame end or overflow: emit unless the frame is empty, then clear
        if (op_i.is_end) begin
          if (count_q != '0) begin
            load     = 1'b1;
            kind_d   = KIND_VERDICT;
            status_d = verdict;
            rlen_d   = len_q;
            rseq_d   = seq_q;
            rcmd_d   = cmd_q;
            done_d   = 1'b1;
          end
        end else begin
          load   = 1'b1;
          kind_d = KIND_OVERFLOW;
          done_d = 1'b1;
        end
        count_d = '0;
        crc_d   = CRC_START;
        rcrc_d  = '0;
        magic_d = '0;
        ver_d   = '0;
        seq_d   = '0;
        cmd_d   = '0;
        len_d   = '0;
      end else begin
        count_d = count_q + 1'b1;
        if (count_q == CNT_W'(POS_MAGIC))   magic_d = op_i.data;
        if (count_q == CNT_W'(POS_VERSION)) ver_d   = op_i.data;
        if (count_q == CNT_W'(POS_SEQ))     seq_d   = op_i.data;
        if (count_q == CNT_W'(POS_CMD))     cmd_d   = op_i.data;
        if (count_q == CNT_W'(POS_LEN))     len_d   = op_i.data;
        // header bytes are always inside crc_pos, so the old length is enough
        priority if (count_w < crc_pos) begin
          crc_d = crc16_byte(crc_q, op_i.data);
        end else if (count_w == crc_pos) begin
          rcrc_d = {rcrc_q[15:8], op_i.data};
        end else if (count_w == crc_pos + 16'd1) begin
          rcrc_d = {op_i.data, rcrc_q[7:0]};
        end else begin
          rcrc_d = rcrc_q;
        end
        load   = 1'b1;
        kind_d = KIND_DATA;
        data_d = op_i.data;
        idx_d  = IDX_W'(count_q);
      end
      if (load) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= CRC_START;
      rcrc_q      <= '0;
      magic_q     <= '0;
      ver_q       <= '0;
      seq_q       <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      rcrc_q      <= rcrc_d;
      magic_q     <= magic_d;
      ver_q       <= ver_d;
      seq_q       <= seq_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      rlen_q   <= rlen_d;
      rseq_q   <= rseq_d;
      rcmd_q   <= rcmd_d;
      done_q   <= done_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.kind              = kind_q;
  assign res_o.data_byte         = data_q;
  assign res_o.byte_index        = idx_q;
  assign res_o.status            = status_q;
  assign res_o.frame_payload_len = rlen_q;
  assign res_o.frame_seq         = rseq_q;
  assign res_o.frame_cmd         = rcmd_q;
  assign res_o.frame_done        = done_q;

endmodule

`default_nettype wire

// ===== design/slip_frame_receiver_crc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// rx_i     in   valid / ready      rx_byte
// res_o    out  valid / ready      kind, data_byte, byte_index, status,
//                                  frame_payload_len, frame_seq, frame_cmd, frame_done
//
// one request per cycle if res_o accepts; queued, then held in the result register
// throughput is set by the byte-wide crc update in the frame checker, one byte a cycle
// rst_ni clears the escape flag, queue pointers, frame state and output valid at once
// a stalled output holds its register and backs up the two-entry queue; rx_i.ready
// drops only when that queue is full

module slip_frame_receiver_crc_check (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slipfr_in_if.sink  rx_i,
  slipfr_out_if.source res_o
);
  import slipfr_pkg::*;

  op_t  fr_op;
  logic fr_valid;
  logic fr_ready;
  op_t  bk_op;
  logic bk_valid;
  logic bk_ready;

  slipfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .op_o       (fr_op),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready)
  );

  slipfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_op_i    (fr_op),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_op_o    (bk_op),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  slipfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (bk_op),
    .op_valid_i (bk_valid),
    .op_ready_o (bk_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== design/slipfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slipfr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] kind_i,
  input wire logic [2:0] status_i,
  input wire logic [8:0] byte_index_i,
  input wire logic       frame_done_i
);
  import slipfr_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // frame_done marks exactly the verdict and overflow results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_done_i == (kind_i != KIND_DATA)))
    else $error("frame_done does not match kind");

  // only verdicts carry a nonzero status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_VERDICT) |-> status_i == ST_OK)
    else $error("status set outside a verdict");

  // after a frame closes the next data byte starts at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && frame_done_i ##1 out_valid_i && kind_i == KIND_DATA
      |-> byte_index_i == '0)
    else $error("new frame does not start at index zero");

endmodule

bind slip_frame_receiver_crc_check slipfr_checker u_slipfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .kind_i       (res_o.kind),
  .status_i     (res_o.status),
  .byte_index_i (res_o.byte_index),
  .frame_done_i (res_o.frame_done)
);

`default_nettype wire
